### design/ipv4rs_pkg.sv
`default_nettype none

package ipv4rs_pkg;

	// result status codes
	localparam logic [1:0] STAT_BAD      = 2'd0;
	localparam logic [1:0] STAT_FULL     = 2'd1;
	localparam logic [1:0] STAT_PENDING  = 2'd2;
	localparam logic [1:0] STAT_COMPLETE = 2'd3;

	localparam logic [15:0] END_LIMIT     = 16'hFFFF;
	localparam logic [16:0] GOT_MAX       = 17'h1FFFF;
	localparam logic [31:0] TIMEOUT_RESET = 32'd30000;

	typedef struct packed {
		logic [15:0] ident;
		logic [31:0] src;
		logic [31:0] dst;
		logic [7:0]  proto;
	} key_t;

	typedef struct packed {
		key_t        key;
		logic [31:0] stamp;
		logic [16:0] got;
		logic        saw_last;
		logic [15:0] total;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	// outcome of checking one live slot against the fragment
	typedef struct packed {
		logic expired;
		logic match;
	} eval_t;

endpackage

`default_nettype wire

### design/ipv4rs_ram.sv
`default_nettype none

module ipv4rs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### design/ipv4rs_slot_eval.sv
`default_nettype none

module ipv4rs_slot_eval
	import ipv4rs_pkg::*;
(
	input  wire logic [31:0] now_ms,
	input  wire logic [31:0] timeout_ms,
	input  wire key_t        frag_key,
	input  wire rec_t        slot_rec,
	output eval_t            result
);

	logic [31:0] age;

	// idle time wraps modulo 2^32
	assign age = now_ms - slot_rec.stamp;

	always_comb begin
		result.expired = age > timeout_ms;
		result.match   = slot_rec.key == frag_key;
	end

endmodule

`default_nettype wire

### design/ipv4_reassembly_slot_tracker.sv
`default_nettype none

// IPv4 fragment reassembly slot tracker. Each fragment descriptor on the
// s_axis side yields one result on the m_axis side: bad fragment, table full,
// pending (with the slot used) or datagram complete (with slot and total
// length). Slot keys and counters live in a table RAM with one read and one
// write port that is scanned one slot per cycle in order, expiring idle
// slots on the way and stopping at the first live key match; a matching or
// newly allocated fragment then passes through an update state and a result
// state, where it waits until the output register is free. A rejected
// fragment goes straight to the result state, as does one that finds the
// table full. The scan runs through the table's read port. s_axis_tready is
// low while a fragment is in work. The timeout register is written through
// cfg_valid/cfg_data while the block is idle.

module ipv4_reassembly_slot_tracker
	import ipv4rs_pkg::*;
#(
	parameter int SLOT_COUNT = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [31:0]  cfg_data,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// now_ms[31:0], datagram_id[47:32], source_address[79:48],
	// dest_addr[111:80], proto_number[119:112],
	// byte_offset[135:120], fragment_bytes[151:136]
	input  wire logic [151:0] s_axis_tdata,
	// more_follow[0]
	input  wire logic [0:0]   s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// slot_index[2:0], datagram_bytes[18:3], zero[23:19]
	output logic [23:0]       m_axis_tdata,
	// status[1:0]
	output logic [1:0]        m_axis_tuser
);

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W = $clog2(SLOT_COUNT + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SLOT_COUNT - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_UPDATE,
		S_RESULT
	} state_t;

	state_t state_q;

	logic [31:0]          timeout_q;
	logic [SLOT_COUNT-1:0] busy_q;

	key_t        key_q;
	logic [31:0] now_q;
	logic [15:0] len_q;
	logic [15:0] end_q;
	logic        more_q;

	logic [CNT_W-1:0] rd_ptr_q;
	logic             issue_q;
	logic             chk_valid_s1;
	logic [IDX_W-1:0] chk_idx_s1;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic             alloc_q;
	rec_t             rec_q;

	logic [1:0]  res_status_q;
	logic [2:0]  res_slot_q;
	logic [15:0] res_bytes_q;

	logic        m_valid_q;
	logic [1:0]  m_status_q;
	logic [2:0]  m_slot_q;
	logic [15:0] m_bytes_q;
	logic        out_load;

	// input field views
	logic [15:0] in_offset;
	logic [15:0] in_len;
	logic [16:0] in_end;
	logic        in_bad;

	assign in_offset = s_axis_tdata[135:120];
	assign in_len    = s_axis_tdata[151:136];
	assign in_end    = {1'b0, in_offset} + {1'b0, in_len};
	assign in_bad    = (in_len == 16'd0) || (in_end > {1'b0, END_LIMIT});

	// table RAM
	logic [REC_W-1:0] ram_rdata;
	rec_t             rd_rec;
	logic             ram_we;
	rec_t             wr_rec;

	assign rd_rec = rec_t'(ram_rdata);

	ipv4rs_ram #(
		.WIDTH (REC_W),
		.DEPTH (SLOT_COUNT)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (hit_idx_q),
		.wdata (wr_rec),
		.raddr (rd_ptr_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	eval_t ev;

	ipv4rs_slot_eval u_eval (
		.now_ms     (now_q),
		.timeout_ms (timeout_q),
		.frag_key   (key_q),
		.slot_rec   (rd_rec),
		.result     (ev)
	);

	// update arithmetic
	logic [16:0] base_got;
	logic [17:0] got_sum;
	logic [16:0] got_new;
	logic        saw_new;
	logic [15:0] total_new;
	logic        complete;

	always_comb begin
		base_got  = alloc_q ? 17'd0 : rec_q.got;
		got_sum   = {1'b0, base_got} + {2'b00, len_q};
		got_new   = (got_sum > {1'b0, GOT_MAX}) ? GOT_MAX : got_sum[16:0];
		saw_new   = !more_q || (!alloc_q && rec_q.saw_last);
		total_new = !more_q ? end_q : (alloc_q ? 16'd0 : rec_q.total);
		complete  = saw_new && (got_new >= {1'b0, total_new});

		wr_rec.key      = key_q;
		wr_rec.stamp    = now_q;
		wr_rec.got      = got_new;
		wr_rec.saw_last = saw_new;
		wr_rec.total    = total_new;
		ram_we          = state_q == S_UPDATE;
	end

	// scan decisions for the slot read last cycle
	logic             chk_busy;
	logic             chk_free;
	logic             chk_last;
	logic [IDX_W-1:0] pick_free;
	logic [IDX_W+2:0] hit_ext;

	always_comb begin
		chk_busy  = busy_q[chk_idx_s1];
		chk_free  = !chk_busy || ev.expired;
		chk_last  = chk_idx_s1 == LAST_IDX;
		pick_free = free_found_q ? free_idx_q : chk_idx_s1;
		hit_ext   = {3'b000, hit_idx_q};
	end

	assign cfg_ready     = state_q == S_IDLE;
	assign s_axis_tready = state_q == S_IDLE;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {5'b00000, m_bytes_q, m_slot_q};
	assign m_axis_tuser  = m_status_q;

	// output register takes a new result once the previous one has gone
	assign out_load = (state_q == S_RESULT) && (!m_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			timeout_q    <= TIMEOUT_RESET;
			busy_q       <= '0;
			rd_ptr_q     <= '0;
			issue_q      <= 1'b0;
			chk_valid_s1 <= 1'b0;
			free_found_q <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cfg_valid) begin
						timeout_q <= cfg_data;
					end
					if (s_axis_tvalid) begin
						now_q        <= s_axis_tdata[31:0];
						key_q.ident  <= s_axis_tdata[47:32];
						key_q.src    <= s_axis_tdata[79:48];
						key_q.dst    <= s_axis_tdata[111:80];
						key_q.proto  <= s_axis_tdata[119:112];
						len_q        <= in_len;
						end_q        <= in_end[15:0];
						more_q       <= s_axis_tuser[0];
						rd_ptr_q     <= '0;
						issue_q      <= 1'b1;
						chk_valid_s1 <= 1'b0;
						free_found_q <= 1'b0;
						if (in_bad) begin
							res_status_q <= STAT_BAD;
							res_slot_q   <= 3'd0;
							res_bytes_q  <= 16'd0;
							state_q      <= S_RESULT;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (issue_q) begin
						rd_ptr_q <= rd_ptr_q + CNT_W'(1);
						if (rd_ptr_q == LAST_CNT) begin
							issue_q <= 1'b0;
						end
					end
					chk_valid_s1 <= issue_q;
					chk_idx_s1   <= rd_ptr_q[IDX_W-1:0];
					if (chk_valid_s1) begin
						if (chk_busy && ev.expired) begin
							busy_q[chk_idx_s1] <= 1'b0;
						end
						if (chk_free && !free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q   <= chk_idx_s1;
						end
						if (!chk_free && ev.match) begin
							rec_q     <= rd_rec;
							hit_idx_q <= chk_idx_s1;
							alloc_q   <= 1'b0;
							state_q   <= S_UPDATE;
						end else if (chk_last) begin
							if (free_found_q || chk_free) begin
								hit_idx_q <= pick_free;
								alloc_q   <= 1'b1;
								state_q   <= S_UPDATE;
							end else begin
								res_status_q <= STAT_FULL;
								res_slot_q   <= 3'd0;
								res_bytes_q  <= 16'd0;
								state_q      <= S_RESULT;
							end
						end
					end
				end
				S_UPDATE: begin
					// a finished datagram releases its slot at once
					busy_q[hit_idx_q] <= !complete;
					res_slot_q        <= hit_ext[2:0];
					if (complete) begin
						res_status_q <= STAT_COMPLETE;
						res_bytes_q  <= total_new;
					end else begin
						res_status_q <= STAT_PENDING;
						res_bytes_q  <= 16'd0;
					end
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (out_load) begin
						m_status_q <= res_status_q;
						m_slot_q   <= res_slot_q;
						m_bytes_q  <= res_bytes_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### design/ipv4rs_checker.sv
`default_nettype none

module ipv4rs_checker
	import ipv4rs_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [23:0] m_axis_tdata,
	input wire logic [1:0]  m_axis_tuser
);

	// a stalled result holds still
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// one fragment at a time: no transfer straight after another
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while a fragment is in work");

	// rejected and table-full results carry no slot and no length
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == STAT_BAD || m_axis_tuser == STAT_FULL)
			|-> m_axis_tdata[18:0] == 19'd0)
		else $error("rejected result with slot or length");

	// pending results report no length; pad bits stay zero
	a_pending_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == STAT_PENDING
			|-> m_axis_tdata[23:3] == 21'd0)
		else $error("pending result with length");

endmodule

bind ipv4_reassembly_slot_tracker ipv4rs_checker u_ipv4rs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
